### sv/pixel_format_to_rgba8_defines.svh
// Assertion macros shared by the conversion block.
`ifndef PIXEL_FORMAT_TO_RGBA8_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGBA8_DEFINES_SVH

// Condition and consequence in the same cycle.
`define PFRGBA_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence checked in the cycle after the condition.
`define PFRGBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pfrgba_pkg.sv
package pfrgba_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIXEL_FORMAT = 1'b0,
    REG_PALETTE_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    FMT_GREY1      = 4'd0,
    FMT_GREY2      = 4'd1,
    FMT_GREY4      = 4'd2,
    FMT_GREY8      = 4'd3,
    FMT_ALPHA_GREY = 4'd4,
    FMT_GREY_ALPHA = 4'd5,
    FMT_RGB        = 4'd6,
    FMT_ARGB       = 4'd7,
    FMT_RGBA       = 4'd8,
    FMT_INDEX1     = 4'd9,
    FMT_INDEX2     = 4'd10,
    FMT_INDEX4     = 4'd11,
    FMT_INDEX8     = 4'd12
  } fmt_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_INDEX_RANGE = 2'd1,
    ST_UNSUPPORTED = 2'd2
  } status_t;

  typedef enum logic {
    CMD_CONVERT = 1'b0,
    CMD_WRITE   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] pixel_bytes;
    logic [2:0]  column_low;
    logic [7:0]  entry_index;
    logic [31:0] entry_color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    status_t    status;
  } out_item_t;

  // Colour word laid out like a palette entry: red in the low byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } color_t;

  typedef struct packed {
    color_t     color;
    status_t    status;
    logic       use_pal;
    logic [7:0] index;
  } unpack_t;

endpackage

### sv/pfrgba_if.sv
interface pfrgba_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pfrgba_ram.sv
module pfrgba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/pfrgba_unpack.sv
module pfrgba_unpack (
  input  pfrgba_pkg::fmt_t    pixel_format,
  input  logic [31:0]         pixel_bytes,
  input  logic [2:0]          column_low,
  output pfrgba_pkg::unpack_t decode
);
  import pfrgba_pkg::*;

  logic [7:0] b0, b1, b2, b3;
  logic       v1;
  logic [1:0] v2;
  logic [3:0] v4;

  assign b0 = pixel_bytes[7:0];
  assign b1 = pixel_bytes[15:8];
  assign b2 = pixel_bytes[23:16];
  assign b3 = pixel_bytes[31:24];

  // Sub-byte pixels are packed most significant first.
  assign v1 = b0[~column_low];
  assign v2 = 2'(b0 >> {~column_low[1:0], 1'b0});
  assign v4 = 4'(b0 >> {~column_low[0], 2'b00});

  always_comb begin
    decode = '0;
    decode.status = ST_OK;
    unique case (pixel_format)
      FMT_GREY1: begin
        decode.color = {8'hFF, {3{{8{v1}}}}};
      end
      FMT_GREY2: begin
        // v * 85 is the 2-bit value repeated across the byte.
        decode.color = {8'hFF, {3{{4{v2}}}}};
      end
      FMT_GREY4: begin
        decode.color = {8'hFF, {3{{2{v4}}}}};
      end
      FMT_GREY8:      decode.color = {8'hFF, b0, b0, b0};
      FMT_ALPHA_GREY: decode.color = {b0, b1, b1, b1};
      FMT_GREY_ALPHA: decode.color = {b1, b0, b0, b0};
      FMT_RGB:        decode.color = {8'hFF, b2, b1, b0};
      FMT_ARGB:       decode.color = {b0, b3, b2, b1};
      FMT_RGBA:       decode.color = {b3, b2, b1, b0};
      FMT_INDEX1: begin
        decode.use_pal = 1'b1;
        decode.index   = {7'd0, v1};
      end
      FMT_INDEX2: begin
        decode.use_pal = 1'b1;
        decode.index   = {6'd0, v2};
      end
      FMT_INDEX4: begin
        decode.use_pal = 1'b1;
        decode.index   = {4'd0, v4};
      end
      FMT_INDEX8: begin
        decode.use_pal = 1'b1;
        decode.index   = b0;
      end
      default: decode.status = ST_UNSUPPORTED;
    endcase
  end
endmodule

### sv/pixel_format_to_rgba8.sv
// Pixel to RGBA8888 converter. Takes one beat per clock on the pixel channel
// while the rgba channel takes results, and returns the converted colour on
// the rgba channel after the first stage and the output register; the rate is
// set by the single registered read port of the palette RAM, which serves one
// lookup per clock. A palette write beat returns nothing. pixel_format and
// palette_size must only be changed while no beat is in flight. Palette
// entries are undefined after reset until written; there is no clearing pass,
// so software loads every entry it will reference before using index formats.
module pixel_format_to_rgba8 #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pfrgba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pfrgba_pkg::CFG_DATA_W-1:0]   cfg_data,
  pfrgba_if.sink                              pixel,
  pfrgba_if.source                            rgba
);
  import pfrgba_pkg::*;

`include "pixel_format_to_rgba8_defines.svh"

  localparam int         IDX_W     = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

  fmt_t       pixel_format;
  logic [8:0] palette_size;

  unpack_t    dec;
  logic       in_range;
  logic       accept;
  logic       conv_accept;
  logic       wr_en;
  logic       s1_free;
  logic       out_free;

  logic       s1_valid;
  color_t     s1_color;
  status_t    s1_status;
  logic       s1_pal_hit;

  logic [31:0] rd_data;
  color_t      sel_color;
  logic        out_valid;
  out_item_t   out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_GREY8;
      palette_size <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PIXEL_FORMAT: pixel_format <= fmt_t'(cfg_data[3:0]);
        REG_PALETTE_SIZE: palette_size <= cfg_data;
      endcase
    end
  end

  pfrgba_unpack u_unpack (
    .pixel_format (pixel_format),
    .pixel_bytes  (pixel.data.pixel_bytes),
    .column_low   (pixel.data.column_low),
    .decode       (dec)
  );

  assign in_range = ({1'b0, dec.index} < palette_size) && ({1'b0, dec.index} < DEPTH_LIM);

  assign out_free    = !out_valid || rgba.ready;
  assign s1_free     = !s1_valid || out_free;
  assign pixel.ready = s1_free;
  assign accept      = pixel.valid && s1_free;
  assign conv_accept = accept && (pixel.data.command == CMD_CONVERT);
  assign wr_en       = accept && (pixel.data.command == CMD_WRITE)
                       && ({1'b0, pixel.data.entry_index} < DEPTH_LIM);

  // The read data holds while the lookup waits in the first stage.
  pfrgba_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pixel.data.entry_index[IDX_W-1:0]),
    .wdata (pixel.data.entry_color),
    .re    (conv_accept),
    .raddr (dec.index[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= conv_accept;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (conv_accept) begin
      s1_color   <= dec.color;
      s1_pal_hit <= dec.use_pal && in_range;
      s1_status  <= (dec.use_pal && !in_range) ? ST_INDEX_RANGE : dec.status;
    end
    if (out_free && s1_valid) begin
      out_data.red    <= sel_color.red;
      out_data.green  <= sel_color.green;
      out_data.blue   <= sel_color.blue;
      out_data.alpha  <= sel_color.alpha;
      out_data.status <= s1_status;
    end
  end

  assign sel_color  = s1_pal_hit ? color_t'(rd_data) : s1_color;
  assign rgba.valid = out_valid;
  assign rgba.data  = out_data;

  `PFRGBA_ASSERT_HOLDS(a_err_no_color, out_valid && out_data.status != ST_OK, out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0 && out_data.alpha == 8'd0, "error result carries colour")
  `PFRGBA_ASSERT_NEXT(a_convert_enters, conv_accept, s1_valid, "convert beat lost at entry")
  `PFRGBA_ASSERT_NEXT(a_stage_held, s1_valid && !out_free, s1_valid && $stable(s1_color) && $stable(s1_status), "stalled stage changed")

endmodule

### tb/sv/pixel_format_to_rgba8_test.sv
module pixel_format_to_rgba8_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pfrgba_pkg::*;

  localparam int PAL_DEPTH = 256;
  localparam int RAND_PHASES = 28;
  localparam int ITEMS_PER_PHASE = 51;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 400;

  localparam logic [3:0] FMT_UNSUP_LO = 4'd13;
  localparam logic [3:0] FMT_UNSUP_HI = 4'd15;

  localparam out_item_t WHITE     = {32'hFFFF_FFFF, ST_OK};
  localparam out_item_t BLACK     = {24'd0, 8'hFF, ST_OK};
  localparam out_item_t RANGE_ERR = {32'd0, ST_INDEX_RANGE};
  localparam out_item_t UNSUP_OUT = {32'd0, ST_UNSUPPORTED};

  typedef struct packed {
    logic      pinned;
    out_item_t want;
  } pin_t;

  typedef struct packed {
    logic [3:0] fmt;
    logic [8:0] psize;
    in_item_t   beat;
    logic       pinned;
    out_item_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfrgba_if #(.payload_t(in_item_t)) pixel_ch ();
  pfrgba_if #(.payload_t(out_item_t)) rgba_ch ();

  pixel_format_to_rgba8 #(.PALETTE_DEPTH(PAL_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel    (pixel_ch),
    .rgba     (rgba_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mirror of the block's configuration and palette.
  logic [3:0]  fmt_now = FMT_GREY8;
  logic [8:0]  psize_now = '0;
  logic [31:0] palette_copy [PAL_DEPTH];

  // Entries the stimulus has loaded, so that no unloaded entry is ever looked up.
  bit loaded [PAL_DEPTH];

  out_item_t rgba_due [$];
  pin_t      pin_q [$];

  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int mismatches = 0;
  int beats_in = 0;
  int writes_sent = 0;
  int checked = 0;
  int reg_writes = 0;

  dir_row_t dir_rows [25];

  function automatic int sub_pixel(logic [7:0] b, int bits, logic [2:0] col);
    int per;
    int shift;
    per = 8 / bits;
    shift = bits * (per - 1 - (int'(col) % per));
    return (int'(b) >> shift) & ((1 << bits) - 1);
  endfunction

  function automatic logic [7:0] grey_level(int v, int bits);
    return 8'(v * 255 / ((1 << bits) - 1));
  endfunction

  // Palette index selected by an index format, or -1 for any other format.
  function automatic int pal_index(logic [3:0] fmt, logic [7:0] b0, logic [2:0] col);
    case (fmt)
      FMT_INDEX1: return sub_pixel(b0, 1, col);
      FMT_INDEX2: return sub_pixel(b0, 2, col);
      FMT_INDEX4: return sub_pixel(b0, 4, col);
      FMT_INDEX8: return int'(b0);
      default:    return -1;
    endcase
  endfunction

  function automatic out_item_t unpack_pixel(in_item_t beat);
    out_item_t res;
    color_t c;
    logic [7:0] b0, b1, b2, b3;
    logic [2:0] col;
    int idx;
    {b3, b2, b1, b0} = beat.pixel_bytes;
    col = beat.column_low;
    res.status = ST_OK;
    c = '0;
    idx = pal_index(fmt_now, b0, col);
    case (fmt_now)
      FMT_GREY1:      c = {8'hFF, {3{grey_level(sub_pixel(b0, 1, col), 1)}}};
      FMT_GREY2:      c = {8'hFF, {3{grey_level(sub_pixel(b0, 2, col), 2)}}};
      FMT_GREY4:      c = {8'hFF, {3{grey_level(sub_pixel(b0, 4, col), 4)}}};
      FMT_GREY8:      c = {8'hFF, {3{b0}}};
      FMT_ALPHA_GREY: c = {b0, {3{b1}}};
      FMT_GREY_ALPHA: c = {b1, {3{b0}}};
      FMT_RGB:        c = {8'hFF, b2, b1, b0};
      FMT_ARGB:       c = {b0, b3, b2, b1};
      FMT_RGBA:       c = {b3, b2, b1, b0};
      FMT_INDEX1, FMT_INDEX2, FMT_INDEX4, FMT_INDEX8: begin
        if (idx >= psize_now || idx >= PAL_DEPTH) begin
          res.status = ST_INDEX_RANGE;
        end else begin
          c = palette_copy[idx];
        end
      end
      default: res.status = ST_UNSUPPORTED;
    endcase
    res.red = c.red;
    res.green = c.green;
    res.blue = c.blue;
    res.alpha = c.alpha;
    return res;
  endfunction

  function automatic dir_row_t cv(logic [3:0] fmt, logic [8:0] psize, logic [31:0] px,
                                  logic [2:0] col);
    dir_row_t r;
    r = '0;
    r.fmt = fmt;
    r.psize = psize;
    r.beat.command = CMD_CONVERT;
    r.beat.pixel_bytes = px;
    r.beat.column_low = col;
    return r;
  endfunction

  function automatic dir_row_t wr(logic [3:0] fmt, logic [8:0] psize, logic [7:0] idx,
                                  logic [31:0] color);
    dir_row_t r;
    r = '0;
    r.fmt = fmt;
    r.psize = psize;
    r.beat.command = CMD_WRITE;
    r.beat.entry_index = idx;
    r.beat.entry_color = color;
    return r;
  endfunction

  function automatic dir_row_t pin(dir_row_t r, out_item_t want);
    r.pinned = 1'b1;
    r.want = want;
    return r;
  endfunction

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      REG_PIXEL_FORMAT: fmt_now = val[3:0];
      REG_PALETTE_SIZE: psize_now = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid, let every pending pixel drain, and then keep waiting so that any
  // palette write in flight also lands, since it produces nothing to wait on.
  task automatic settle();
    @(negedge clk);
    pixel_ch.valid = 1'b0;
    while (rgba_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_beat(in_item_t beat, logic pinned, out_item_t want);
    pin_t p;
    p.pinned = pinned;
    p.want = want;
    pin_q.push_back(p);
    if (beat.command == CMD_WRITE) begin
      writes_sent++;
      if (beat.entry_index < PAL_DEPTH) loaded[beat.entry_index] = 1'b1;
    end
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      pixel_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pixel_ch.valid = 1'b1;
    pixel_ch.data = beat;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  // Accepted beats on both channels: prediction on the way in, checking on the way out.
  always @(posedge clk) begin
    in_item_t seen;
    out_item_t got;
    out_item_t want;
    pin_t p;
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        seen = pixel_ch.data;
        p = pin_q.pop_front();
        beats_in++;
        if (seen.command == CMD_WRITE) begin
          if (seen.entry_index < PAL_DEPTH) palette_copy[seen.entry_index] = seen.entry_color;
        end else begin
          rgba_due.push_back(p.pinned ? p.want : unpack_pixel(seen));
        end
      end
      if (rgba_ch.valid && rgba_ch.ready) begin
        got = rgba_ch.data;
        if (rgba_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("rgba beat with no pixel pending: r=%h g=%h b=%h a=%h st=%0d",
                     got.red, got.green, got.blue, got.alpha, got.status);
        end else begin
          want = rgba_due.pop_front();
          checked++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
              got.alpha !== want.alpha || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel %0d: expected r=%h g=%h b=%h a=%h st=%0d, got r=%h g=%h b=%h a=%h st=%0d",
                       checked, want.red, want.green, want.blue, want.alpha, want.status,
                       got.red, got.green, got.blue, got.alpha, got.status);
          end
        end
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    rgba_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rgba_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rgba_ch.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        rgba_ch.ready = 1'b0;
      end else begin
        rgba_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_ch.valid && pixel_ch.ready) || (rgba_ch.valid && rgba_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no beat moved for %0d cycles", STALL_LIMIT);
    $display("pixel_format_to_rgba8: mismatch");
    $finish;
  end

  initial begin
    in_item_t beat;
    in_item_t fill;
    logic [3:0] fmt;
    logic [8:0] ps;
    int idx;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data = '0;

    dir_rows = '{
      pin(cv(FMT_GREY8, 9'd0, 32'h0000_00AB, 3'd0), {8'hAB, 8'hAB, 8'hAB, 8'hFF, ST_OK}),
      pin(cv(FMT_GREY8, 9'd0, 32'hFFFF_FFFF, 3'd7), WHITE),
      pin(cv(FMT_GREY1, 9'd0, 32'h0000_0080, 3'd0), WHITE),
      pin(cv(FMT_GREY1, 9'd0, 32'h0000_0080, 3'd1), BLACK),
      pin(cv(FMT_GREY1, 9'd0, 32'hFFFF_FF01, 3'd7), WHITE),
      pin(cv(FMT_GREY2, 9'd0, 32'h0000_001B, 3'd3), WHITE),
      cv(FMT_GREY2, 9'd0, 32'h0000_001B, 3'd5),
      pin(cv(FMT_GREY4, 9'd0, 32'h0000_00F0, 3'd0), WHITE),
      pin(cv(FMT_GREY4, 9'd0, 32'hFFFF_FFF0, 3'd7), BLACK),
      cv(FMT_ALPHA_GREY, 9'd0, 32'h4433_2211, 3'd0),
      cv(FMT_GREY_ALPHA, 9'd0, 32'h4433_2211, 3'd0),
      cv(FMT_RGB, 9'd0, 32'h4433_2211, 3'd0),
      cv(FMT_ARGB, 9'd0, 32'h4433_2211, 3'd0),
      cv(FMT_RGBA, 9'd0, 32'h4433_2211, 3'd0),
      wr(FMT_RGBA, 9'd0, 8'd0, 32'h0403_0201),
      wr(FMT_RGBA, 9'd0, 8'd255, 32'hFFFF_FFFF),
      wr(FMT_RGBA, 9'd0, 8'd1, 32'h8040_2010),
      cv(FMT_INDEX8, 9'd256, 32'h0000_00FF, 3'd0),
      cv(FMT_INDEX8, 9'd256, 32'h0000_0000, 3'd0),
      pin(cv(FMT_INDEX8, 9'd0, 32'h0000_0000, 3'd0), RANGE_ERR),
      cv(FMT_INDEX1, 9'd2, 32'h0000_0080, 3'd0),
      pin(cv(FMT_INDEX2, 9'd1, 32'h0000_0040, 3'd0), RANGE_ERR),
      cv(FMT_INDEX4, 9'd511, 32'h0000_0010, 3'd6),
      pin(cv(FMT_UNSUP_LO, 9'd511, 32'h0000_00FF, 3'd0), UNSUP_OUT),
      pin(cv(FMT_UNSUP_HI, 9'd511, 32'hFFFF_FFFF, 3'd7), UNSUP_OUT)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // The first rows run on the reset configuration.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fmt != fmt_now || dir_rows[i].psize != psize_now) begin
        settle();
        if (dir_rows[i].fmt != fmt_now)
          set_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(dir_rows[i].fmt));
        if (dir_rows[i].psize != psize_now) set_reg(REG_PALETTE_SIZE, dir_rows[i].psize);
      end
      push_beat(dir_rows[i].beat, dir_rows[i].pinned, dir_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      calm = (ph >= RAND_PHASES - 3);
      if (ph < 16)
        fmt = 4'(ph);
      else if ($urandom_range(0, 1) == 0)
        fmt = 4'($urandom_range(FMT_INDEX1, FMT_INDEX8));
      else
        fmt = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 5))
        0: ps = 9'd0;
        1: ps = 9'd256;
        2: ps = 9'd511;
        3: ps = 9'($urandom_range(1, 16));
        4: ps = 9'($urandom_range(0, 511));
        default: ps = 9'($urandom_range(17, 255));
      endcase
      set_reg(REG_PIXEL_FORMAT, CFG_DATA_W'(fmt));
      set_reg(REG_PALETTE_SIZE, ps);
      if (ph == 4 || ph == 17) begin
        @(posedge clk);
        hold_request = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        beat.command = ($urandom_range(0, 6) == 0) ? CMD_WRITE : CMD_CONVERT;
        beat.pixel_bytes = $urandom();
        beat.column_low = 3'($urandom_range(0, 7));
        beat.entry_index = 8'($urandom_range(0, 255));
        beat.entry_color = $urandom();
        if (beat.command == CMD_CONVERT) begin
          idx = pal_index(fmt_now, beat.pixel_bytes[7:0], beat.column_low);
          // An in-range entry that was never loaded gets loaded just before its lookup.
          if (idx >= 0 && idx < psize_now && idx < PAL_DEPTH && !loaded[idx]) begin
            fill = beat;
            fill.command = CMD_WRITE;
            fill.entry_index = 8'(idx);
            fill.entry_color = $urandom();
            push_beat(fill, 1'b0, '0);
          end
        end
        push_beat(beat, 1'b0, '0);
      end
    end

    @(negedge clk);
    pixel_ch.valid = 1'b0;
    while (rgba_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d pixel-channel beats (%0d palette loads) over %0d register writes.",
             beats_in, writes_sent, reg_writes);
    $display("Checked %0d converted pixels across all formats; %0d failed.",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("pixel_format_to_rgba8: match");
    end else begin
      $display("pixel_format_to_rgba8: mismatch");
    end
    $finish;
  end

endmodule
